### rtl/core/rcl_pkg.sv
// shared types, constants and functions of the reduced cipher bias counter
package rcl_pkg;

   localparam int ROUND_COUNT = 1;
   // every round has two substitution layers, plus one final layer
   localparam int LAYER_COUNT = 2 * ROUND_COUNT + 1;
   localparam int BYTE_COUNT = 8;
   localparam int BLOCK_WIDTH = 64;
   localparam int COUNT_WIDTH = 32;
   localparam int CSR_INDEX_WIDTH = 1;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
   localparam logic [BLOCK_WIDTH-1:0] PLAIN_MASK_RESET = 64'h0000_0000_0073_0000;
   localparam logic [BLOCK_WIDTH-1:0] CIPHER_MASK_RESET = 64'h0F0F_0000_000E_0000;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PLAIN_MASK = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CIPHER_MASK = 1'b1;

   typedef logic [7:0] byte_type;
   typedef logic [BLOCK_WIDTH-1:0] block_type;
   typedef logic [COUNT_WIDTH-1:0] count_type;
   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;

   // what travels down the substitution pipeline with each transaction
   typedef struct packed {
      block_type data;
      logic      plain_parity;
      logic      restart;
   } stage_payload_type;

   localparam byte_type SBOX_TABLE [256] = '{
      8'd51, 8'd36, 8'd78, 8'd193, 8'd141, 8'd154, 8'd231, 8'd21,
      8'd240, 8'd127, 8'd89, 8'd171, 8'd2, 8'd104, 8'd188, 8'd214,
      8'd66, 8'd85, 8'd63, 8'd176, 8'd252, 8'd235, 8'd150, 8'd100,
      8'd129, 8'd14, 8'd40, 8'd218, 8'd115, 8'd25, 8'd205, 8'd167,
      8'd228, 8'd243, 8'd153, 8'd22, 8'd90, 8'd77, 8'd48, 8'd194,
      8'd39, 8'd168, 8'd142, 8'd124, 8'd213, 8'd191, 8'd107, 8'd1,
      8'd28, 8'd11, 8'd97, 8'd238, 8'd162, 8'd181, 8'd200, 8'd58,
      8'd223, 8'd80, 8'd118, 8'd132, 8'd45, 8'd71, 8'd147, 8'd249,
      8'd216, 8'd207, 8'd165, 8'd42, 8'd102, 8'd113, 8'd12, 8'd254,
      8'd27, 8'd148, 8'd178, 8'd64, 8'd233, 8'd131, 8'd87, 8'd61,
      8'd169, 8'd190, 8'd212, 8'd91, 8'd23, 8'd0, 8'd125, 8'd143,
      8'd106, 8'd229, 8'd195, 8'd49, 8'd152, 8'd242, 8'd38, 8'd76,
      8'd126, 8'd105, 8'd3, 8'd140, 8'd192, 8'd215, 8'd170, 8'd88,
      8'd189, 8'd50, 8'd20, 8'd230, 8'd79, 8'd37, 8'd241, 8'd155,
      8'd81, 8'd70, 8'd44, 8'd163, 8'd239, 8'd248, 8'd133, 8'd119,
      8'd146, 8'd29, 8'd59, 8'd201, 8'd96, 8'd10, 8'd222, 8'd180,
      8'd15, 8'd24, 8'd114, 8'd253, 8'd177, 8'd166, 8'd219, 8'd41,
      8'd204, 8'd67, 8'd101, 8'd151, 8'd62, 8'd84, 8'd128, 8'd234,
      8'd247, 8'd224, 8'd138, 8'd5, 8'd73, 8'd94, 8'd35, 8'd209,
      8'd52, 8'd187, 8'd157, 8'd111, 8'd198, 8'd172, 8'd120, 8'd18,
      8'd149, 8'd130, 8'd232, 8'd103, 8'd43, 8'd60, 8'd65, 8'd179,
      8'd86, 8'd217, 8'd255, 8'd13, 8'd164, 8'd206, 8'd26, 8'd112,
      8'd186, 8'd173, 8'd199, 8'd72, 8'd4, 8'd19, 8'd110, 8'd156,
      8'd121, 8'd246, 8'd208, 8'd34, 8'd139, 8'd225, 8'd53, 8'd95,
      8'd32, 8'd55, 8'd93, 8'd210, 8'd158, 8'd137, 8'd244, 8'd6,
      8'd227, 8'd108, 8'd74, 8'd184, 8'd17, 8'd123, 8'd175, 8'd197,
      8'd134, 8'd145, 8'd251, 8'd116, 8'd56, 8'd47, 8'd82, 8'd160,
      8'd69, 8'd202, 8'd236, 8'd30, 8'd183, 8'd221, 8'd9, 8'd99,
      8'd203, 8'd220, 8'd182, 8'd57, 8'd117, 8'd98, 8'd31, 8'd237,
      8'd8, 8'd135, 8'd161, 8'd83, 8'd250, 8'd144, 8'd68, 8'd46,
      8'd109, 8'd122, 8'd16, 8'd159, 8'd211, 8'd196, 8'd185, 8'd75,
      8'd174, 8'd33, 8'd7, 8'd245, 8'd92, 8'd54, 8'd226, 8'd136
   };

   // bit transpose of the 8x8 byte matrix: out byte i bit 7-j = in byte j bit 7-i
   function automatic block_type flip_matrix(input block_type value);
      block_type result;
      result = '0;
      for (int i = 0; i < BYTE_COUNT; i++) begin
         for (int j = 0; j < BYTE_COUNT; j++) begin
            result[8*i + 7 - j] = value[8*j + 7 - i];
         end
      end
      return result;
   endfunction

endpackage

### rtl/core/reduced_cipher_linear_bias_counter.sv
// top level: reduced cipher pipeline with linear-approximation match counter
// path: a transaction passes every registered substitution layer, then the result register, before rsp_valid
// throughput: one transaction per cycle while results are taken, set by one registered substitution layer per stage
// every stage and the result register hold a transaction, so a stalled result still
// lets transactions enter until the pipeline is full
// synchronous reset empties the pipeline, clears the match count and restores both masks
module reduced_cipher_linear_bias_counter (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  rcl_pkg::block_type     req_plaintext,
   input  logic                   req_restart,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rcl_pkg::block_type     rsp_ciphertext,
   output logic                   rsp_parities_equal,
   output rcl_pkg::count_type     rsp_match_total,
   input  logic                   csr_wr_en,
   input  rcl_pkg::csr_index_type csr_index,
   input  rcl_pkg::block_type     csr_wdata
);
   import rcl_pkg::*;

   block_type plain_mask_ff;
   block_type cipher_mask_ff;

   logic              stage_valid [LAYER_COUNT+1];
   logic              stage_ready [LAYER_COUNT+1];
   stage_payload_type stage_payload [LAYER_COUNT+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         plain_mask_ff <= PLAIN_MASK_RESET;
         cipher_mask_ff <= CIPHER_MASK_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PLAIN_MASK:  plain_mask_ff <= csr_wdata;
            CSR_CIPHER_MASK: cipher_mask_ff <= csr_wdata;
            default:         ;
         endcase
      end
   end

   // input parity is taken at entry so the plaintext need not travel along
   assign stage_valid[0] = req_valid;
   assign req_ready = stage_ready[0];
   assign stage_payload[0].data = req_plaintext;
   assign stage_payload[0].plain_parity = ^(req_plaintext & plain_mask_ff);
   assign stage_payload[0].restart = req_restart;

   for (genvar k = 0; k < LAYER_COUNT; k++) begin : g_layer
      rcl_sub_stage u_stage (
         .clock        (clock),
         .reset        (reset),
         .flip_en      (k < LAYER_COUNT - 1 ? 1'b1 : 1'b0),
         .up_valid     (stage_valid[k]),
         .up_ready     (stage_ready[k]),
         .up_payload   (stage_payload[k]),
         .down_valid   (stage_valid[k+1]),
         .down_ready   (stage_ready[k+1]),
         .down_payload (stage_payload[k+1])
      );
   end

   rcl_merge u_merge (
      .clock              (clock),
      .reset              (reset),
      .cipher_mask        (cipher_mask_ff),
      .up_valid           (stage_valid[LAYER_COUNT]),
      .up_ready           (stage_ready[LAYER_COUNT]),
      .up_payload         (stage_payload[LAYER_COUNT]),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_ciphertext     (rsp_ciphertext),
      .rsp_parities_equal (rsp_parities_equal),
      .rsp_match_total    (rsp_match_total)
   );

endmodule

### rtl/core/rcl_sbox_lane.sv
// one byte lane: substitution of a single byte through the fixed table
module rcl_sbox_lane (
   input  rcl_pkg::byte_type lane_in,
   output rcl_pkg::byte_type lane_out
);
   import rcl_pkg::*;

   assign lane_out = SBOX_TABLE[lane_in];

endmodule

### rtl/core/rcl_sub_stage.sv
// one registered substitution layer: eight byte lanes and an optional transpose
module rcl_sub_stage (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       flip_en,
   input  logic                       up_valid,
   output logic                       up_ready,
   input  rcl_pkg::stage_payload_type up_payload,
   output logic                       down_valid,
   input  logic                       down_ready,
   output rcl_pkg::stage_payload_type down_payload
);
   import rcl_pkg::*;

   logic              valid_ff;
   logic              valid_in;
   stage_payload_type payload_ff;
   stage_payload_type payload_in;
   block_type         sub_data;

   for (genvar k = 0; k < BYTE_COUNT; k++) begin : g_lane
      rcl_sbox_lane u_lane (
         .lane_in  (up_payload.data[8*k +: 8]),
         .lane_out (sub_data[8*k +: 8])
      );
   end

   // the stage takes a new transaction whenever it is empty or drains this cycle
   assign up_ready = !valid_ff || down_ready;

   always_comb begin
      valid_in = up_ready ? up_valid : valid_ff;
      payload_in = up_payload;
      payload_in.data = flip_en ? flip_matrix(sub_data) : sub_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (up_ready && up_valid) begin
         payload_ff <= payload_in;
      end
   end

   assign down_valid = valid_ff;
   assign down_payload = payload_ff;

endmodule

### rtl/core/rcl_merge.sv
// merging stage: output parity, match decision, saturating count, result register
module rcl_merge (
   input  logic                       clock,
   input  logic                       reset,
   input  rcl_pkg::block_type         cipher_mask,
   input  logic                       up_valid,
   output logic                       up_ready,
   input  rcl_pkg::stage_payload_type up_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rcl_pkg::block_type         rsp_ciphertext,
   output logic                       rsp_parities_equal,
   output rcl_pkg::count_type         rsp_match_total
);
   import rcl_pkg::*;

   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   block_type ciphertext_ff;
   logic      equal_ff;
   logic      equal_in;
   count_type total_ff;
   count_type count_ff;
   count_type count_in;
   count_type count_base;
   logic      take;

   assign up_ready = !rsp_valid_ff || rsp_ready;
   assign take = up_ready && up_valid;

   always_comb begin
      equal_in = up_payload.plain_parity == (^(up_payload.data & cipher_mask));
      // restart clears the count before this transaction is counted
      count_base = up_payload.restart ? '0 : count_ff;
      count_in = count_ff;
      if (take) begin
         count_in = (equal_in && count_base != COUNT_MAX) ? count_base + 1'b1 : count_base;
      end
      rsp_valid_in = up_ready ? up_valid : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         count_ff <= count_in;
      end
      if (take) begin
         ciphertext_ff <= up_payload.data;
         equal_ff <= equal_in;
         total_ff <= count_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_ciphertext = ciphertext_ff;
   assign rsp_parities_equal = equal_ff;
   assign rsp_match_total = total_ff;

endmodule

### rtl/core/rcl_checker.sv
// port-level checker for the reduced cipher bias counter, bound to the top level
module rcl_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input rcl_pkg::block_type     rsp_ciphertext,
   input logic                   rsp_parities_equal,
   input rcl_pkg::count_type     rsp_match_total
);
   import rcl_pkg::*;

   localparam int PendWidth = $clog2(LAYER_COUNT + 2) + 1;

   logic [PendWidth-1:0] pend_ff;
   logic [PendWidth-1:0] pend_in;
   logic                 req_take;
   logic                 rsp_take;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   // transactions accepted but not yet delivered
   always_comb begin
      pend_in = pend_ff;
      if (req_take && !rsp_take) begin
         pend_in = pend_ff + 1'b1;
      end else if (rsp_take && !req_take) begin
         pend_in = pend_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ciphertext)
         && $stable(rsp_match_total) && $stable(rsp_parities_equal))
      else $error("stalled result changed");

   a_match_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_parities_equal |-> rsp_match_total != '0)
      else $error("match reported with zero count");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != '0)
      else $error("result without an accepted transaction");

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= PendWidth'(LAYER_COUNT + 1))
      else $error("more transactions in flight than pipeline slots");

endmodule

bind reduced_cipher_linear_bias_counter rcl_checker u_rcl_checker (.*);

### test/tb.sv
// testbench for the reduced cipher linear bias counter, checked against a local predictor
`timescale 1ns / 1ps

module tb;
   import rcl_pkg::*;

   localparam int ROUNDS = rcl_pkg::ROUND_COUNT;
   localparam int PHASE_COUNT = 8;
   localparam int PHASE_ITEMS = 230;
   localparam int SETTLE_CYCLES = LAYER_COUNT + 4;

   localparam bit [7:0] SBOX_LUT [256] = '{
      8'd51, 8'd36, 8'd78, 8'd193, 8'd141, 8'd154, 8'd231, 8'd21,
      8'd240, 8'd127, 8'd89, 8'd171, 8'd2, 8'd104, 8'd188, 8'd214,
      8'd66, 8'd85, 8'd63, 8'd176, 8'd252, 8'd235, 8'd150, 8'd100,
      8'd129, 8'd14, 8'd40, 8'd218, 8'd115, 8'd25, 8'd205, 8'd167,
      8'd228, 8'd243, 8'd153, 8'd22, 8'd90, 8'd77, 8'd48, 8'd194,
      8'd39, 8'd168, 8'd142, 8'd124, 8'd213, 8'd191, 8'd107, 8'd1,
      8'd28, 8'd11, 8'd97, 8'd238, 8'd162, 8'd181, 8'd200, 8'd58,
      8'd223, 8'd80, 8'd118, 8'd132, 8'd45, 8'd71, 8'd147, 8'd249,
      8'd216, 8'd207, 8'd165, 8'd42, 8'd102, 8'd113, 8'd12, 8'd254,
      8'd27, 8'd148, 8'd178, 8'd64, 8'd233, 8'd131, 8'd87, 8'd61,
      8'd169, 8'd190, 8'd212, 8'd91, 8'd23, 8'd0, 8'd125, 8'd143,
      8'd106, 8'd229, 8'd195, 8'd49, 8'd152, 8'd242, 8'd38, 8'd76,
      8'd126, 8'd105, 8'd3, 8'd140, 8'd192, 8'd215, 8'd170, 8'd88,
      8'd189, 8'd50, 8'd20, 8'd230, 8'd79, 8'd37, 8'd241, 8'd155,
      8'd81, 8'd70, 8'd44, 8'd163, 8'd239, 8'd248, 8'd133, 8'd119,
      8'd146, 8'd29, 8'd59, 8'd201, 8'd96, 8'd10, 8'd222, 8'd180,
      8'd15, 8'd24, 8'd114, 8'd253, 8'd177, 8'd166, 8'd219, 8'd41,
      8'd204, 8'd67, 8'd101, 8'd151, 8'd62, 8'd84, 8'd128, 8'd234,
      8'd247, 8'd224, 8'd138, 8'd5, 8'd73, 8'd94, 8'd35, 8'd209,
      8'd52, 8'd187, 8'd157, 8'd111, 8'd198, 8'd172, 8'd120, 8'd18,
      8'd149, 8'd130, 8'd232, 8'd103, 8'd43, 8'd60, 8'd65, 8'd179,
      8'd86, 8'd217, 8'd255, 8'd13, 8'd164, 8'd206, 8'd26, 8'd112,
      8'd186, 8'd173, 8'd199, 8'd72, 8'd4, 8'd19, 8'd110, 8'd156,
      8'd121, 8'd246, 8'd208, 8'd34, 8'd139, 8'd225, 8'd53, 8'd95,
      8'd32, 8'd55, 8'd93, 8'd210, 8'd158, 8'd137, 8'd244, 8'd6,
      8'd227, 8'd108, 8'd74, 8'd184, 8'd17, 8'd123, 8'd175, 8'd197,
      8'd134, 8'd145, 8'd251, 8'd116, 8'd56, 8'd47, 8'd82, 8'd160,
      8'd69, 8'd202, 8'd236, 8'd30, 8'd183, 8'd221, 8'd9, 8'd99,
      8'd203, 8'd220, 8'd182, 8'd57, 8'd117, 8'd98, 8'd31, 8'd237,
      8'd8, 8'd135, 8'd161, 8'd83, 8'd250, 8'd144, 8'd68, 8'd46,
      8'd109, 8'd122, 8'd16, 8'd159, 8'd211, 8'd196, 8'd185, 8'd75,
      8'd174, 8'd33, 8'd7, 8'd245, 8'd92, 8'd54, 8'd226, 8'd136
   };

   typedef struct packed {
      block_type ciphertext;
      logic      parities_equal;
      count_type match_total;
   } outcome_t;

   typedef struct packed {
      block_type plaintext;
      logic      restart;
      bit        zero_masks;
      bit        typed;
      logic      parities_equal;
      count_type match_total;
   } directed_row_t;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   block_type     req_plaintext = '0;
   logic          req_restart = 1'b0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   block_type     rsp_ciphertext;
   logic          rsp_parities_equal;
   count_type     rsp_match_total;
   logic          csr_wr_en = 1'b0;
   csr_index_type csr_index = CSR_PLAIN_MASK;
   block_type     csr_wdata = '0;

   // predictor state
   block_type plain_sel;
   block_type cipher_sel;
   count_type bias_hits;

   outcome_t      pending_outcomes [$];
   outcome_t      head;
   directed_row_t directed_rows [15];
   int            error_count = 0;
   int            send_idle_pct = 12;
   int            recv_idle_pct = 53;

   reduced_cipher_linear_bias_counter dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic block_type substitute(block_type value);
      block_type result;
      for (int k = 0; k < BYTE_COUNT; k++) begin
         result[8*k +: 8] = SBOX_LUT[value[8*k +: 8]];
      end
      return result;
   endfunction

   // row r of the result collects bit 7-r of every input byte
   function automatic block_type transpose_bits(block_type value);
      block_type result;
      for (int row = 0; row < BYTE_COUNT; row++) begin
         for (int col = 0; col < BYTE_COUNT; col++) begin
            result[8*row + 7 - col] = value[8*col + 7 - row];
         end
      end
      return result;
   endfunction

   function automatic block_type encrypt_block(block_type plaintext);
      block_type state;
      state = plaintext;
      for (int r = 0; r < ROUNDS; r++) begin
         state = transpose_bits(substitute(state));
         state = transpose_bits(substitute(state));
      end
      return substitute(state);
   endfunction

   function automatic outcome_t predict_outcome(block_type plaintext, logic restart);
      outcome_t result;
      result.ciphertext = encrypt_block(plaintext);
      result.parities_equal = ((^(plaintext & plain_sel)) == (^(result.ciphertext & cipher_sel)));
      if (restart) begin
         bias_hits = '0;
      end
      if (result.parities_equal && bias_hits != COUNT_MAX) begin
         bias_hits = bias_hits + 1'b1;
      end
      result.match_total = bias_hits;
      return result;
   endfunction

   function automatic block_type rand_block();
      return {$urandom, $urandom};
   endfunction

   function automatic block_type rand_plaintext();
      case ($urandom_range(15))
         0: return '0;
         1: return '1;
         2: return block_type'(1) << $urandom_range(63);
         default: return rand_block();
      endcase
   endfunction

   task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      $display("%0t mismatch on %s: got %h, want %h", $realtime, field, got, want);
      error_count++;
   endtask

   // hold the sender off until the pipeline has drained
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
   endtask

   task automatic load_masks(block_type plain_value, block_type cipher_value);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_PLAIN_MASK;
      csr_wdata <= plain_value;
      @(posedge clock);
      csr_index <= CSR_CIPHER_MASK;
      csr_wdata <= cipher_value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      plain_sel = plain_value;
      cipher_sel = cipher_value;
   endtask

   task automatic send_item(block_type plaintext, logic restart, bit typed = 1'b0,
                            logic parities_equal = 1'b0, count_type match_total = '0);
      outcome_t want;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_plaintext <= plaintext;
      req_restart <= restart;
      do @(posedge clock); while (req_ready !== 1'b1);
      want = predict_outcome(plaintext, restart);
      if (typed) begin
         want.parities_equal = parities_equal;
         want.match_total = match_total;
      end
      pending_outcomes.push_back(want);
   endtask

   // result side: check at the edge, then pick the next stall
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (pending_outcomes.size() == 0) begin
            report_mismatch("result with no transaction pending", rsp_ciphertext, '0);
         end else begin
            head = pending_outcomes.pop_front();
            if (rsp_ciphertext !== head.ciphertext)
               report_mismatch("ciphertext", rsp_ciphertext, head.ciphertext);
            if (rsp_parities_equal !== head.parities_equal)
               report_mismatch("parities_equal", 64'(rsp_parities_equal),
                               64'(head.parities_equal));
            if (rsp_match_total !== head.match_total)
               report_mismatch("match_total", 64'(rsp_match_total), 64'(head.match_total));
         end
      end
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   initial begin
      #2_000_000;
      $display("[reduced_cipher_linear_bias_counter] ERROR");
      $finish;
   end

   initial begin
      int wait_cycles;
      block_type plain_value;
      block_type cipher_value;

      // with both masks zero every transaction matches, so the count is known
      directed_rows = '{
         '{64'h0000_0000_0000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
         '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
         '{64'h0000_0000_0073_0000, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
         '{64'h0F0F_0000_000E_0000, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0},
         '{64'h8000_0000_0000_0001, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
         '{64'h0123_4567_89AB_CDEF, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
         '{64'h0000_0000_0000_0000, 1'b1, 1'b1, 1'b1, 1'b1, 32'd1},
         '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 1'b1, 1'b1, 32'd2},
         '{64'h0000_0000_0000_00FF, 1'b0, 1'b0, 1'b1, 1'b1, 32'd3},
         '{64'hFF00_0000_0000_0000, 1'b0, 1'b0, 1'b1, 1'b1, 32'd4},
         '{64'h5555_5555_5555_5555, 1'b1, 1'b0, 1'b1, 1'b1, 32'd1},
         '{64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, 1'b1, 1'b1, 32'd2},
         '{64'h0000_0000_0000_0001, 1'b1, 1'b0, 1'b1, 1'b1, 32'd1},
         '{64'h8000_0000_0000_0000, 1'b0, 1'b0, 1'b1, 1'b1, 32'd2},
         '{64'hFEDC_BA98_7654_3210, 1'b0, 1'b0, 1'b1, 1'b1, 32'd3}
      };

      plain_sel = 64'h0000_0000_0073_0000;
      cipher_sel = 64'h0F0F_0000_000E_0000;
      bias_hits = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].zero_masks) begin
            settle();
            load_masks('0, '0);
         end
         send_item(directed_rows[i].plaintext, directed_rows[i].restart,
                   directed_rows[i].typed, directed_rows[i].parities_equal,
                   directed_rows[i].match_total);
      end

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: begin plain_value = '1; cipher_value = '1; end
            1: begin plain_value = rand_block(); cipher_value = rand_block(); end
            2: begin
               plain_value = 64'h0000_0000_0073_0000;
               cipher_value = 64'h0F0F_0000_000E_0000;
            end
            3: begin
               plain_value = block_type'(1) << $urandom_range(63);
               cipher_value = rand_block();
            end
            4: begin plain_value = rand_block(); cipher_value = '1; end
            5: begin plain_value = '0; cipher_value = rand_block(); end
            6: begin plain_value = rand_block(); cipher_value = '0; end
            default: begin plain_value = rand_block(); cipher_value = rand_block(); end
         endcase
         if (phase < 3) begin
            send_idle_pct = 12;
            recv_idle_pct = 53;
         end else if (phase < 6) begin
            send_idle_pct = 53;
            recv_idle_pct = 12;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         settle();
         load_masks(plain_value, cipher_value);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 1 && n == PHASE_ITEMS / 2) settle();
            send_item(rand_plaintext(), $urandom_range(39) == 0);
         end
      end

      settle();
      wait_cycles = 0;
      while (wait_cycles < SETTLE_CYCLES) begin
         @(posedge clock);
         wait_cycles++;
      end
      if (error_count == 0 && pending_outcomes.size() == 0) begin
         $display("[reduced_cipher_linear_bias_counter] OK");
      end else begin
         $display("[reduced_cipher_linear_bias_counter] ERROR");
      end
      $finish;
   end

endmodule
